FILE: sv/pplt_pkg.sv
package pplt_pkg;

    localparam int ENTRIES   = 64;
    localparam int PID_BITS  = 16;
    localparam int PAGE_BITS = 20;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int SLOT_W = 6;
    localparam int CALL_W = 10;
    localparam int POL_W  = 2;

    localparam logic [1:0] REQ_CREATE  = 2'd0;
    localparam logic [1:0] REQ_SYSCALL = 2'd1;
    localparam logic [1:0] REQ_MEMORY  = 2'd2;
    localparam logic [1:0] REQ_DESTROY = 2'd3;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_DENIED = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;

    localparam logic [CALL_W-1:0] NET_LO  = CALL_W'(100);
    localparam logic [CALL_W-1:0] NET_HI  = CALL_W'(120);
    localparam logic [CALL_W-1:0] DISK_LO = CALL_W'(50);
    localparam logic [CALL_W-1:0] DISK_HI = CALL_W'(80);

    localparam int POL_NO_NET  = 0;
    localparam int POL_NO_DISK = 1;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [PID_BITS-1:0]  process_id;
        logic [3:0]           policy_bits;
        logic [PAGE_BITS-1:0] page_limit;
        logic [CALL_W-1:0]    call_number;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot_index;
    } rsp_t;

    typedef struct packed {
        logic [PID_BITS-1:0]  process_id;
        logic [POL_W-1:0]     policy;
        logic [PAGE_BITS-1:0] limit;
        logic [PAGE_BITS-1:0] used;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

endpackage

FILE: sv/process_policy_limit_table_unit.sv
// process policy limit table
// requests arrive on req / req_valid / req_stall, one result per request leaves on
// rsp / rsp_valid / rsp_stall. a transfer happens when valid is high and stall is low.
// create writes the next free slot and answers with its index, or with the full status
// once every slot has been handed out; slots are never reused.
// syscall check, memory check and destroy walk the used slots of the record memory one
// slot per cycle through its single registered read port, writing back into the slot
// just read where the request modifies it.
// a create, or any request against an empty table, goes straight to the result state;
// the other kinds first scan the used slots (a memory check stops at its first
// matching record).
// the block takes one request at a time: req_stall is high once a request has been
// accepted until the result has been moved into the output register.
// a result waiting in the output register does not block the next request; only the
// hand-off of the following result waits while rsp_stall is high, and rsp holds.
// reset clears the slot count and the control state; the record memory is not cleared,
// since only data from slots below the count is ever used.
module process_policy_limit_table_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  pplt_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output pplt_pkg::rsp_t rsp
);
    import pplt_pkg::*;

    entry_t mem [ENTRIES];

    state_t            state_reg, state_next;
    req_t              req_reg, req_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              deny_reg, deny_next;
    logic [1:0]        status_reg, status_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    rsp_t              rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    entry_t            rdata_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              mem_we;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;

    logic req_fire;
    logic rsp_free;
    logic hit;
    logic last;
    logic call_net;
    logic call_disk;
    logic sys_deny;
    logic scan_done;

    assign req_fire  = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign hit       = (rdata_reg.process_id == req_reg.process_id);
    assign last      = ((CNT_W'(idx_reg) + CNT_W'(1)) == used_reg);
    assign call_net  = (req_reg.call_number >= NET_LO) && (req_reg.call_number <= NET_HI);
    assign call_disk = (req_reg.call_number >= DISK_LO) && (req_reg.call_number <= DISK_HI);
    assign sys_deny  = hit && ((rdata_reg.policy[POL_NO_NET] && call_net)
                            || (rdata_reg.policy[POL_NO_DISK] && call_disk));
    assign scan_done = last || ((req_reg.req_type == REQ_MEMORY) && hit);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.req_type == REQ_CREATE || used_reg == '0)
                        state_next = ST_RESP;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                    state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (rsp_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        req_next       = req_reg;
        used_next      = used_reg;
        idx_next       = idx_reg;
        deny_next      = deny_reg;
        status_next    = status_reg;
        slot_next      = slot_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rd_addr        = idx_reg + IDX_W'(1);
        mem_we         = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = rdata_reg;

        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = '0;
                if (req_fire)
                begin
                    req_next    = req;
                    idx_next    = '0;
                    deny_next   = 1'b0;
                    status_next = STATUS_OK;
                    slot_next   = '0;
                    if (req.req_type == REQ_CREATE)
                    begin
                        if (used_reg == CNT_W'(ENTRIES))
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            mem_we             = 1'b1;
                            wr_addr            = IDX_W'(used_reg);
                            wr_data.process_id = req.process_id;
                            wr_data.policy     = req.policy_bits[POL_W-1:0];
                            wr_data.limit      = req.page_limit;
                            wr_data.used       = '0;
                            used_next          = used_reg + CNT_W'(1);
                            slot_next          = SLOT_W'(used_reg);
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                case (req_reg.req_type)
                    REQ_SYSCALL:
                    begin
                        deny_next   = deny_reg || sys_deny;
                        status_next = (deny_reg || sys_deny) ? STATUS_DENIED : STATUS_OK;
                    end
                    REQ_MEMORY:
                    begin
                        if (hit)
                        begin
                            if (rdata_reg.used >= rdata_reg.limit)
                            begin
                                status_next = STATUS_DENIED;
                            end
                            else
                            begin
                                mem_we       = 1'b1;
                                wr_data.used = rdata_reg.used + PAGE_BITS'(1);
                            end
                        end
                    end
                    REQ_DESTROY:
                    begin
                        if (hit)
                        begin
                            // limit and count stay in force
                            mem_we             = 1'b1;
                            wr_data.process_id = '0;
                            wr_data.policy     = '0;
                        end
                    end
                    default:
                    begin
                        status_next = STATUS_OK;
                    end
                endcase
                if (!scan_done)
                    idx_next = idx_reg + IDX_W'(1);
            end
            ST_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_next.status     = status_reg;
                    rsp_next.slot_index = slot_reg;
                    rsp_valid_next      = 1'b1;
                end
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        idx_reg    <= idx_next;
        deny_reg   <= deny_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        rsp_reg    <= rsp_next;
    end

    // record memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[rd_addr];
    end

    a_fire_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg != ST_IDLE))
        else $error("accepted request did not start");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(ENTRIES))
        else $error("slot count beyond table size");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (CNT_W'(idx_reg) < used_reg))
        else $error("scan past the used slots");

    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == ST_SCAN)
                 || (req_fire && req.req_type == REQ_CREATE)))
        else $error("unexpected memory write");

    a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESP && rsp_valid_reg && rsp_stall) |=> (state_reg == ST_RESP))
        else $error("result overwrote a pending transfer");

endmodule
